/* hdl/dte_pkg.sv */
`timescale 1ns / 1ps

package dte_pkg;

    localparam int unsigned Latency      = 5;
    localparam int unsigned EpochWidth   = 42;
    localparam logic [15:0] EpochYear    = 16'd1970;
    localparam logic [12:0] RecipDiv25   = 13'd5243;
    localparam int unsigned RecipShift   = 17;
    localparam logic [25:0] DaysTo1970   = 26'd719163;
    localparam logic [11:0] ZoneNotGiven = 12'h801;

    typedef logic [3:0] month_idx_t;
    typedef logic [8:0] day_count_t;

    function automatic day_count_t days_before_month(input month_idx_t idx);
        day_count_t d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

/* hdl/disc_timestamp_to_epoch.sv */
`timescale 1ns / 1ps

// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------------
// input     | start, busy        | year, month, day, hour, minute, second, type_and_zone
// result    | done (one cycle)   | epoch_seconds, before_epoch
//
// five-stage pipeline: a transaction may enter on every cycle, its result shows on done
// once it has passed stages 1 to 5; the stage with the days by 86400 multiplier sets the depth
// busy is always low, the pipeline never stalls since the receiver cannot hold results off
// reset clears the valid bits only, payload registers are not reset

module disc_timestamp_to_epoch (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [15:0]         year,
    input  logic [3:0]          month,
    input  logic [4:0]          day,
    input  logic [4:0]          hour,
    input  logic [5:0]          minute,
    input  logic [5:0]          second,
    input  logic [15:0]         type_and_zone,
    output logic                done,
    output logic signed [41:0]  epoch_seconds,
    output logic                before_epoch
);

    // valid bits
    logic [4:0] valid_reg;
    logic [4:0] valid_next;

    // stage 1
    logic                before1_reg, before1_next;
    logic [15:0]         year1_reg, year1_next;
    logic [15:0]         y1_reg, y1_next;
    logic [26:0]         py100_1_reg, py100_1_next;
    logic [24:0]         py400_1_reg, py400_1_next;
    logic [26:0]         pr100_1_reg, pr100_1_next;
    logic [24:0]         pr400_1_reg, pr400_1_next;
    logic [8:0]          dbm1_reg, dbm1_next;
    logic                late1_reg, late1_next;
    logic [4:0]          day1_reg, day1_next;
    logic signed [19:0]  off1_reg, off1_next;

    // stage 2
    logic                before2_reg, before2_next;
    logic [24:0]         base2_reg, base2_next;
    logic [9:0]          mdays2_reg, mdays2_next;
    logic signed [19:0]  off2_reg, off2_next;

    // stage 3
    logic                before3_reg, before3_next;
    logic signed [25:0]  days3_reg, days3_next;
    logic signed [19:0]  off3_reg, off3_next;

    // stage 4
    logic                before4_reg, before4_next;
    logic signed [42:0]  prod4_reg, prod4_next;
    logic signed [19:0]  off4_reg, off4_next;

    // stage 5
    logic                before5_reg, before5_next;
    logic signed [41:0]  epoch5_reg, epoch5_next;

    logic                accept;
    dte_pkg::month_idx_t midx;
    logic [16:0]         hms;
    logic signed [11:0]  zone;
    logic signed [19:0]  zone60;
    logic [9:0]          qy100, qr100;
    logic [7:0]          qy400, qr400;
    logic                leap;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign valid_next = {valid_reg[3:0], accept};

    // stage 1: month table, quotient products, time of day and zone
    always_comb
    begin
        before1_next = (year < dte_pkg::EpochYear);
        year1_next   = year;
        y1_next      = year - 16'd1;
        py100_1_next = 27'(y1_next[15:2]) * 27'(dte_pkg::RecipDiv25);
        py400_1_next = 25'(y1_next[15:4]) * 25'(dte_pkg::RecipDiv25);
        pr100_1_next = 27'(year[15:2]) * 27'(dte_pkg::RecipDiv25);
        pr400_1_next = 25'(year[15:4]) * 25'(dte_pkg::RecipDiv25);

        if (month == 4'd0)
        begin
            midx = 4'd0;
        end
        else if (month > 4'd12)
        begin
            midx = 4'd11;
        end
        else
        begin
            midx = month - 4'd1;
        end
        dbm1_next  = dte_pkg::days_before_month(midx);
        late1_next = (midx >= 4'd2);
        day1_next  = day;

        hms = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
        zone = $signed(type_and_zone[11:0]);
        if (type_and_zone[12] && (type_and_zone[11:0] != dte_pkg::ZoneNotGiven))
        begin
            zone60 = $signed({{8{zone[11]}}, zone}) * 20'sd60;
        end
        else
        begin
            zone60 = 20'sd0;
        end
        off1_next = $signed({3'b000, hms}) - zone60;
    end

    // stage 2: days up to the start of the year, leap test
    always_comb
    begin
        qy100 = py100_1_reg[26:dte_pkg::RecipShift];
        qy400 = py400_1_reg[24:dte_pkg::RecipShift];
        qr100 = pr100_1_reg[26:dte_pkg::RecipShift];
        qr400 = pr400_1_reg[24:dte_pkg::RecipShift];
        leap  = ((year1_reg[1:0] == 2'b00) && ({1'b0, year1_reg} != 17'(qr100) * 17'd100))
              || ({1'b0, year1_reg} == 17'(qr400) * 17'd400);

        before2_next = before1_reg;
        base2_next   = 25'(y1_reg) * 25'd365 + 25'(y1_reg[15:2]) - 25'(qy100) + 25'(qy400);
        mdays2_next  = 10'(dbm1_reg) + 10'(late1_reg && leap) + 10'(day1_reg);
        off2_next    = off1_reg;
    end

    // stage 3: days since the epoch
    always_comb
    begin
        before3_next = before2_reg;
        days3_next   = $signed({1'b0, base2_reg}) + $signed({16'd0, mdays2_reg})
                     - $signed(dte_pkg::DaysTo1970);
        off3_next    = off2_reg;
    end

    // stage 4: days to seconds
    always_comb
    begin
        before4_next = before3_reg;
        prod4_next   = $signed({{17{days3_reg[25]}}, days3_reg}) * 43'sd86400;
        off4_next    = off3_reg;
    end

    // stage 5: add time of day and zone, force zero before the epoch
    always_comb
    begin
        before5_next = before4_reg;
        if (before4_reg)
        begin
            epoch5_next = '0;
        end
        else
        begin
            epoch5_next = prod4_reg[41:0] + $signed({{22{off4_reg[19]}}, off4_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        before1_reg <= before1_next;
        year1_reg   <= year1_next;
        y1_reg      <= y1_next;
        py100_1_reg <= py100_1_next;
        py400_1_reg <= py400_1_next;
        pr100_1_reg <= pr100_1_next;
        pr400_1_reg <= pr400_1_next;
        dbm1_reg    <= dbm1_next;
        late1_reg   <= late1_next;
        day1_reg    <= day1_next;
        off1_reg    <= off1_next;

        before2_reg <= before2_next;
        base2_reg   <= base2_next;
        mdays2_reg  <= mdays2_next;
        off2_reg    <= off2_next;

        before3_reg <= before3_next;
        days3_reg   <= days3_next;
        off3_reg    <= off3_next;

        before4_reg <= before4_next;
        prod4_reg   <= prod4_next;
        off4_reg    <= off4_next;

        before5_reg <= before5_next;
        epoch5_reg  <= epoch5_next;
    end

    assign done          = valid_reg[4];
    assign epoch_seconds = epoch5_reg;
    assign before_epoch  = before5_reg;

endmodule

/* hdl/dte_checker.sv */
`timescale 1ns / 1ps

module dte_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [15:0]         year,
    input logic                done,
    input logic signed [41:0]  epoch_seconds,
    input logic                before_epoch
);

    // every transaction gives its result after the pipeline depth
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(dte_pkg::Latency) done)
        else $error("result missing after accepted transaction");

    // no result without a transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, dte_pkg::Latency))
        else $error("result without a transaction");

    a_flag_matches_year: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (before_epoch == ($past(year, dte_pkg::Latency) < dte_pkg::EpochYear)))
        else $error("before_epoch does not match year");

    a_zero_before_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (done && before_epoch) |-> (epoch_seconds == '0))
        else $error("seconds not zero before the epoch");

endmodule

bind disc_timestamp_to_epoch dte_checker u_dte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .year          (year),
    .done          (done),
    .epoch_seconds (epoch_seconds),
    .before_epoch  (before_epoch)
);

/* sim/epoch_checker.sv */
`timescale 1ns / 1ps

module epoch_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [15:0]         year,
    input  logic [3:0]          month,
    input  logic [4:0]          day,
    input  logic [4:0]          hour,
    input  logic [5:0]          minute,
    input  logic [5:0]          second,
    input  logic [15:0]         type_and_zone,
    input  logic                done,
    input  logic signed [41:0]  epoch_seconds,
    input  logic                before_epoch,
    output int unsigned         errors,
    output int unsigned         outstanding
);

    typedef struct packed {
        logic signed [41:0] secs;
        logic               pre_epoch;
    } epoch_result_t;

    localparam longint CumDays [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    epoch_result_t pending_epochs[$];

    // days from year 1 up to the end of year y
    function automatic longint days_through_year(input longint unsigned y);
        return longint'(y * 365 + y / 4 - y / 100 + y / 400);
    endfunction

    function automatic epoch_result_t predict_epoch(
        input logic [15:0] yr,
        input logic [3:0]  mo,
        input logic [4:0]  dy,
        input logic [4:0]  hr,
        input logic [5:0]  mn,
        input logic [5:0]  sc,
        input logic [15:0] tz
    );
        epoch_result_t r;
        longint        days;
        longint        secs;
        longint        zone;
        int            midx;
        logic          leap;
        r.secs      = '0;
        r.pre_epoch = 1'b0;
        if (yr < dte_pkg::EpochYear)
        begin
            r.pre_epoch = 1'b1;
            return r;
        end
        days = days_through_year(longint'(yr) - 1) - days_through_year(1969);
        if (mo == 4'd0)
            midx = 0;
        else if (mo > 4'd12)
            midx = 11;
        else
            midx = int'(mo) - 1;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        days += CumDays[midx];
        if (midx >= 2 && leap)
            days += 1;
        days += longint'(dy) - 1;
        secs = days * 86400 + longint'(hr) * 3600 + longint'(mn) * 60 + longint'(sc);
        zone = longint'($signed(tz[11:0]));
        if (tz[12] && tz[11:0] != dte_pkg::ZoneNotGiven)
            secs -= zone * 60;
        r.secs = secs[41:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        epoch_result_t exp_r;
        int unsigned   errs;
        errs = errors;
        if (!rst_n)
        begin
            errs = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_epochs.size() == 0)
                begin
                    $error("unexpected result transaction: epoch_seconds %0d before_epoch %0b",
                           epoch_seconds, before_epoch);
                    errs++;
                end
                else
                begin
                    exp_r = pending_epochs.pop_front();
                    if (epoch_seconds !== exp_r.secs)
                    begin
                        $error("epoch_seconds: expected %0d, actual %0d",
                               exp_r.secs, epoch_seconds);
                        errs++;
                    end
                    if (before_epoch !== exp_r.pre_epoch)
                    begin
                        $error("before_epoch: expected %0b, actual %0b",
                               exp_r.pre_epoch, before_epoch);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                pending_epochs.push_back(predict_epoch(year, month, day, hour, minute,
                                                       second, type_and_zone));
        end
        errors      <= errs;
        outstanding <= pending_epochs.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int WatchdogLimit = 2000;
    localparam int RandomItems   = 600;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [15:0]        year = '0;
    logic [3:0]         month = '0;
    logic [4:0]         day = '0;
    logic [4:0]         hour = '0;
    logic [5:0]         minute = '0;
    logic [5:0]         second = '0;
    logic [15:0]        type_and_zone = '0;
    logic               done;
    logic signed [41:0] epoch_seconds;
    logic               before_epoch;
    int unsigned        errors;
    int unsigned        outstanding;
    int                 idle_pct = 29;
    int                 idle_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    disc_timestamp_to_epoch u_top (.*);

    epoch_checker u_checker (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("disc_timestamp_to_epoch verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_stamp(
        input logic [15:0] yr,
        input logic [3:0]  mo,
        input logic [4:0]  dy,
        input logic [4:0]  hr,
        input logic [5:0]  mn,
        input logic [5:0]  sc,
        input logic [15:0] tz
    );
        bit gap;
        year          <= yr;
        month         <= mo;
        day           <= dy;
        hour          <= hr;
        minute        <= mn;
        second        <= sc;
        type_and_zone <= tz;
        start         <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        gap = 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            if (!gap)
                start <= 1'b0;
            gap = 1'b1;
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic [15:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  sc;
        logic [15:0] tz;
        int          sel;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and corner cases
        send_stamp(16'd0,     4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  16'h1000);
        send_stamp(16'd1969,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 16'h1123);
        send_stamp(16'd1970,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  16'h0000);
        send_stamp(16'd1970,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  16'h17ff);
        send_stamp(16'd1970,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  16'h1800);
        send_stamp(16'd1970,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  16'h1801);
        send_stamp(16'd1970,  4'd1,  5'd0,  5'd0,  6'd0,  6'd0,  16'h1000);
        send_stamp(16'd65535, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 16'h1800);
        send_stamp(16'd65535, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 16'hffff);
        send_stamp(16'd2000,  4'd3,  5'd1,  5'd12, 6'd30, 6'd30, 16'h1078);
        send_stamp(16'd1900,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  16'h1000);
        send_stamp(16'd2100,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  16'h1fc4);
        send_stamp(16'd2004,  4'd2,  5'd29, 5'd23, 6'd59, 6'd59, 16'h1000);
        send_stamp(16'd2004,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  16'h1000);
        send_stamp(16'd2023,  4'd0,  5'd15, 5'd8,  6'd0,  6'd0,  16'h0000);
        send_stamp(16'd2023,  4'd13, 5'd15, 5'd8,  6'd0,  6'd0,  16'h0000);
        send_stamp(16'd2023,  4'd15, 5'd0,  5'd31, 6'd63, 6'd63, 16'h0000);
        send_stamp(16'd2023,  4'd6,  5'd15, 5'd8,  6'd0,  6'd0,  16'hefff);
        send_stamp(16'd2023,  4'd6,  5'd15, 5'd8,  6'd0,  6'd0,  16'he801);
        send_stamp(16'd2023,  4'd6,  5'd15, 5'd8,  6'd0,  6'd0,  16'h2801);
        send_stamp(16'd2038,  4'd1,  5'd19, 5'd3,  6'd14, 6'd8,  16'h1000);
        send_stamp(16'd1970,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  16'h1001);

        for (int n = 0; n < RandomItems; n++)
        begin
            if (n == RandomItems / 3)
                idle_pct = 61;
            if (n == 2 * RandomItems / 3)
                idle_pct = 0;
            sel = $urandom_range(99);
            tz  = 16'($urandom);
            if (sel < 75)
            begin
                if ($urandom_range(9) < 7)
                    yr = 16'($urandom_range(2100, 1970));
                else
                    yr = 16'($urandom_range(65535, 1970));
                mo = 4'($urandom_range(12, 1));
                dy = 5'($urandom_range(31, 1));
                hr = 5'($urandom_range(23, 0));
                mn = 6'($urandom_range(59, 0));
                sc = 6'($urandom_range(59, 0));
                if ($urandom_range(9) < 7)
                    tz[12] = 1'b1;
                if ($urandom_range(9) == 0)
                    tz[11:0] = dte_pkg::ZoneNotGiven;
            end
            else
            begin
                if (sel < 85)
                    yr = 16'($urandom_range(1969, 0));
                else
                    yr = 16'($urandom);
                mo = 4'($urandom);
                dy = 5'($urandom);
                hr = 5'($urandom);
                mn = 6'($urandom);
                sc = 6'($urandom);
            end
            send_stamp(yr, mo, dy, hr, mn, sc, tz);
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (dte_pkg::Latency + 4) @(posedge clk);

        if (errors == 0)
            $display("disc_timestamp_to_epoch verification clean");
        else
            $display("disc_timestamp_to_epoch verification failed");
        $finish;
    end

endmodule

/* disc_timestamp_to_epoch.f */
hdl/dte_pkg.sv
hdl/disc_timestamp_to_epoch.sv
hdl/dte_checker.sv
sim/epoch_checker.sv
sim/tb_top.sv
